[rtl/core/depthwise_causal_conv_packed_top_assert.svh]
// assertion macros used by the filter top module
`ifndef DEPTHWISE_CAUSAL_CONV_PACKED_TOP_ASSERT_SVH
`define DEPTHWISE_CAUSAL_CONV_PACKED_TOP_ASSERT_SVH

// same-cycle implication, checked on the rising clock edge outside reset
`define DCC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// next-cycle implication, checked on the rising clock edge outside reset
`define DCC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

[rtl/core/dcc_pkg.sv]
// shared constants and types of the depthwise causal filter
`timescale 1ns / 1ps

package dcc_pkg;

	// filter shape
	localparam int CHANNELS = 64;
	localparam int TAPS     = 4;

	// field widths
	localparam int CHAN_W = 6;
	localparam int TAP_W  = 2;
	localparam int VAL_W  = 16;
	localparam int PROD_W = 2 * VAL_W;
	localparam int FILT_W = 40;

	// memory geometry: one row per channel
	localparam int ADDR_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int HIST_TAPS = TAPS - 1;
	localparam int HIST_W    = ((HIST_TAPS > 0) ? HIST_TAPS : 1) * VAL_W;
	localparam int WROW_W    = TAPS * VAL_W;

	// stream packing
	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 48;

	// item kinds carried on tuser
	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_LOAD   = 1'b1;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_SUM
	} dcc_state_t;

	// control from the sequencer to the multiply-accumulate unit
	typedef struct packed {
		logic mul_en;
		logic hist_clr;
	} dcc_mac_ctrl_t;

endpackage

[rtl/core/dcc_ram.sv]
// generic single-port synchronous ram with registered read
`timescale 1ns / 1ps

module dcc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                                         clk,
	input  logic                                         en,
	input  logic                                         we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
	input  logic [WIDTH-1:0]                             wdata,
	output logic [WIDTH-1:0]                             rdata
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem [DEPTH];
	logic [AW-1:0]    unused_aw;

	assign unused_aw = addr;

	// write or read one row per cycle
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end
			rdata <= mem[addr];
		end
	end

endmodule

[rtl/core/dcc_mac.sv]
// window assembly, tap multipliers and sum of products
`timescale 1ns / 1ps

module dcc_mac (
	input  logic                             clk,
	input  dcc_pkg::dcc_mac_ctrl_t           ctrl,
	input  logic [dcc_pkg::HIST_W-1:0]       hist_rd,
	input  logic [dcc_pkg::WROW_W-1:0]       wt_rd,
	input  logic signed [dcc_pkg::VAL_W-1:0] value,
	output logic [dcc_pkg::HIST_W-1:0]       hist_wr,
	output logic signed [dcc_pkg::FILT_W-1:0] sum
);

	import dcc_pkg::*;

	logic signed [VAL_W-1:0]  win [TAPS];
	logic signed [PROD_W-1:0] prod_s1 [TAPS];

	// window: stored history, oldest first, then the current sample
	always_comb begin
		for (int t = 0; t < TAPS; t++) begin
			if (t == TAPS - 1) begin
				win[t] = value;
			end else if (ctrl.hist_clr) begin
				win[t] = '0;
			end else begin
				win[t] = hist_rd[t*VAL_W +: VAL_W];
			end
		end
	end

	// history shifts by one sample
	always_comb begin
		hist_wr = '0;
		for (int t = 0; t < HIST_TAPS; t++) begin
			hist_wr[t*VAL_W +: VAL_W] = win[t+1];
		end
	end

	// one exact 16x16 product per tap
	always_ff @(posedge clk) begin
		if (ctrl.mul_en) begin
			for (int t = 0; t < TAPS; t++) begin
				prod_s1[t] <= $signed(wt_rd[t*VAL_W +: VAL_W]) * win[t];
			end
		end
	end

	// full-precision sum of the registered products
	always_comb begin
		sum = '0;
		for (int t = 0; t < TAPS; t++) begin
			sum = sum + FILT_W'(prod_s1[t]);
		end
	end

endmodule

[rtl/core/depthwise_causal_conv_packed_top.sv]
// channel | dir | handshake        | payload
// s       | in  | s_tvalid/tready  | tuser: cmd; tdata: chan, tap_index, seq_start, value
// m       | out | m_tvalid/tready  | tdata: out_chan, filtered
//
// a sample steps through accept with row read, then products and history write, then sum
// a load steps through accept with row read, then the weight row written back merged
// the weight and history rows of a channel share one ram port each
// reset clears per-channel history valid bits, so history reads as zero at once
// a sample holds in its sum cycle while the output register keeps an untaken result
// the result waits in an output register while the next item is accepted
`timescale 1ns / 1ps

`include "depthwise_causal_conv_packed_top_assert.svh"

module depthwise_causal_conv_packed_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [dcc_pkg::IN_TDATA_W-1:0]      s_tdata,  // chan, tap_index, seq_start, value
	input  logic                                s_tuser,  // cmd
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [dcc_pkg::OUT_TDATA_W-1:0]     m_tdata   // out_chan, filtered
);

	import dcc_pkg::*;

	dcc_state_t state_q, state_d;

	// input field split
	logic [CHAN_W-1:0]       s_chan;
	logic [TAP_W-1:0]        s_tap;
	logic                    s_start;
	logic signed [VAL_W-1:0] s_value;
	logic [IN_TDATA_W-1:0]   unused_tdata;
	logic                    chan_ok;

	// item registers
	logic                    cmd_q;
	logic [ADDR_W-1:0]       chan_q;
	logic [TAP_W-1:0]        tap_q;
	logic                    start_q;
	logic signed [VAL_W-1:0] value_q;

	// memory side
	logic                    ram_en;
	logic [ADDR_W-1:0]       ram_addr;
	logic                    wt_we;
	logic                    hist_we;
	logic [WROW_W-1:0]       wt_rdata, wt_wdata;
	logic [HIST_W-1:0]       hist_rdata, hist_wdata;
	logic [CHANNELS-1:0]     hist_vld_q;

	// datapath and output
	dcc_mac_ctrl_t           mac_ctrl;
	logic signed [FILT_W-1:0] sum;
	logic                    out_load;
	logic                    out_vld_q;
	logic [CHAN_W-1:0]       out_chan_q;
	logic signed [FILT_W-1:0] filt_q;

	assign s_chan       = s_tdata[CHAN_W-1:0];
	assign s_tap        = s_tdata[CHAN_W +: TAP_W];
	assign s_start      = s_tdata[CHAN_W+TAP_W];
	assign s_value      = s_tdata[CHAN_W+TAP_W+1 +: VAL_W];
	assign unused_tdata = s_tdata;
	assign chan_ok      = 32'(s_chan) < CHANNELS;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and sequencer outputs
	always_comb begin
		state_d           = state_q;
		s_tready          = 1'b0;
		ram_en            = 1'b0;
		ram_addr          = chan_q;
		wt_we             = 1'b0;
		hist_we           = 1'b0;
		mac_ctrl.mul_en   = 1'b0;
		mac_ctrl.hist_clr = start_q || !hist_vld_q[chan_q];
		out_load          = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				ram_addr = ADDR_W'(s_chan);
				if (s_tvalid && chan_ok) begin
					ram_en  = 1'b1;
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				if (cmd_q == CMD_LOAD) begin
					ram_en  = 32'(tap_q) < TAPS;
					wt_we   = ram_en;
					state_d = ST_IDLE;
				end else begin
					ram_en          = 1'b1;
					hist_we         = 1'b1;
					mac_ctrl.mul_en = 1'b1;
					state_d         = ST_SUM;
				end
			end
			ST_SUM: begin
				if (!out_vld_q || m_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// capture the accepted item
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_q   <= s_tuser;
			chan_q  <= ADDR_W'(s_chan);
			tap_q   <= s_tap;
			start_q <= s_start;
			value_q <= s_value;
		end
	end

	// weight row with the loaded tap replaced
	always_comb begin
		wt_wdata = wt_rdata;
		wt_wdata[tap_q*VAL_W +: VAL_W] = value_q;
	end

	dcc_ram #(
		.WIDTH(WROW_W),
		.DEPTH(CHANNELS)
	) u_wt_ram (
		.clk  (clk),
		.en   (ram_en),
		.we   (wt_we),
		.addr (ram_addr),
		.wdata(wt_wdata),
		.rdata(wt_rdata)
	);

	dcc_ram #(
		.WIDTH(HIST_W),
		.DEPTH(CHANNELS)
	) u_hist_ram (
		.clk  (clk),
		.en   (ram_en),
		.we   (hist_we),
		.addr (ram_addr),
		.wdata(hist_wdata),
		.rdata(hist_rdata)
	);

	// a history row is valid once a sample of its channel is written back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_vld_q <= '0;
		end else if (hist_we) begin
			hist_vld_q[chan_q] <= 1'b1;
		end
	end

	dcc_mac u_mac (
		.clk    (clk),
		.ctrl   (mac_ctrl),
		.hist_rd(hist_rdata),
		.wt_rd  (wt_rdata),
		.value  (value_q),
		.hist_wr(hist_wdata),
		.sum    (sum)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_chan_q <= CHAN_W'(chan_q);
			filt_q     <= sum;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = OUT_TDATA_W'({filt_q, out_chan_q});

	// checks
	`DCC_ASSERT_NEXT(a_accept_reads, s_tvalid && s_tready && chan_ok, state_q == ST_READ)
	`DCC_ASSERT_NOW(a_write_in_read, wt_we || hist_we, state_q == ST_READ && ram_en)
	`DCC_ASSERT_NOW(a_one_write, 1'b1, $onehot0({wt_we, hist_we}))
	`DCC_ASSERT_NEXT(a_load_no_result, state_q == ST_READ && cmd_q == CMD_LOAD,
		state_q == ST_IDLE)

endmodule

[test/dcc_filter_checker.sv]
// stream monitor, filter predictor and result checker for the depthwise causal filter
`timescale 1ns / 1ps

module dcc_filter_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [dcc_pkg::IN_TDATA_W-1:0]  s_tdata,   // chan, tap_index, seq_start, value
	input  logic                            s_tuser,   // cmd
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [dcc_pkg::OUT_TDATA_W-1:0] m_tdata,   // out_chan, filtered
	output int                              errors,
	output int                              pending
);

	import dcc_pkg::*;

	typedef struct packed {
		logic [CHAN_W-1:0] ch;
		logic [FILT_W-1:0] sum;
	} filt_res_t;

	// shadow copies of the weight rows and the sample history
	logic signed [VAL_W-1:0] coeff_mem [CHANNELS][TAPS];
	logic signed [VAL_W-1:0] hist_mem [CHANNELS][HIST_TAPS];

	filt_res_t filt_q[$];
	int        err_cnt;

	initial begin
		err_cnt = 0;
		errors  = 0;
		pending = 0;
		for (int c = 0; c < CHANNELS; c++) begin
			for (int t = 0; t < TAPS; t++) begin
				coeff_mem[c][t] = '0;
			end
			for (int t = 0; t < HIST_TAPS; t++) begin
				hist_mem[c][t] = '0;
			end
		end
	end

	// one filter step: window of past samples plus the current one, then shift
	function automatic filt_res_t fir_step(input logic [CHAN_W-1:0] ch, input logic st,
			input logic signed [VAL_W-1:0] smp);
		logic signed [VAL_W-1:0]  win [TAPS];
		logic signed [PROD_W-1:0] prod;
		logic signed [FILT_W-1:0] acc;
		filt_res_t                res;
		int                       t;
		acc = '0;
		for (t = 0; t < TAPS - 1; t++) begin
			win[t] = st ? '0 : hist_mem[ch][t];
		end
		win[TAPS-1] = smp;
		for (t = 0; t < TAPS; t++) begin
			prod = coeff_mem[ch][t] * win[t];
			acc  = acc + prod;
		end
		for (t = 0; t < TAPS - 1; t++) begin
			hist_mem[ch][t] = win[t+1];
		end
		res.ch  = ch;
		res.sum = acc;
		return res;
	endfunction

	// watch both channels on the clock edge
	always @(posedge clk) begin
		logic [CHAN_W-1:0]       in_ch;
		logic [TAP_W-1:0]        in_tap;
		logic                    in_start;
		logic signed [VAL_W-1:0] in_val;
		logic [CHAN_W-1:0]       got_ch;
		logic [FILT_W-1:0]       got_sum;
		filt_res_t               want;
		if (arst_n) begin
			// result transfer: compare with the oldest prediction
			if (m_tvalid && m_tready) begin
				got_ch  = m_tdata[CHAN_W-1:0];
				got_sum = m_tdata[CHAN_W +: FILT_W];
				if (filt_q.size() == 0) begin
					err_cnt++;
					$display("%0t unexpected result: chan %0d filtered %0d", $time,
						got_ch, $signed(got_sum));
				end else begin
					want = filt_q.pop_front();
					if (got_ch !== want.ch) begin
						err_cnt++;
						$display("%0t out_chan mismatch: expected %0d actual %0d",
							$time, want.ch, got_ch);
					end
					if (got_sum !== want.sum) begin
						err_cnt++;
						$display("%0t filtered mismatch (chan %0d): expected %0d actual %0d",
							$time, want.ch, $signed(want.sum), $signed(got_sum));
					end
				end
			end
			// input transfer: update the shadow state, predict sample results
			if (s_tvalid && s_tready) begin
				in_ch    = s_tdata[CHAN_W-1:0];
				in_tap   = s_tdata[CHAN_W +: TAP_W];
				in_start = s_tdata[CHAN_W + TAP_W];
				in_val   = s_tdata[CHAN_W + TAP_W + 1 +: VAL_W];
				if (s_tuser == CMD_LOAD) begin
					coeff_mem[in_ch][in_tap] = in_val;
				end else begin
					filt_q.push_back(fir_step(in_ch, in_start, in_val));
				end
			end
			pending <= filt_q.size();
			errors  <= err_cnt;
		end
	end

endmodule

[test/tb_top.sv]
// stimulus, stall control and verdict for the depthwise causal filter
`timescale 1ns / 1ps

module tb_top;
	import dcc_pkg::*;

	localparam int RAND_ITEMS  = 800;
	localparam int CYCLE_LIMIT = 200000;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;   // chan, tap_index, seq_start, value
	logic                   s_tuser;   // cmd
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;   // out_chan, filtered
	int                     errors;
	int                     pending;
	int                     cycles;

	// channels whose four taps have all been loaded may take samples
	logic [TAPS-1:0] taps_loaded [CHANNELS];
	int              ready_q[$];

	depthwise_causal_conv_packed_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	dcc_filter_checker u_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.errors   (errors),
		.pending  (pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// run limit
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	// result side: random stalls, one long hold-off, one stretch always ready
	initial begin
		int rx_cyc;
		m_tready = 1'b0;
		rx_cyc   = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			rx_cyc++;
			if (rx_cyc >= 600 && rx_cyc < 900)
				m_tready <= 1'b0;
			else if (rx_cyc >= 1500 && rx_cyc < 2500)
				m_tready <= 1'b1;
			else
				m_tready <= ($urandom_range(0, 99) >= 14);
		end
	end

	// mostly random values, with the extremes mixed in
	function automatic logic [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'hFFFF;
			default: return VAL_W'($urandom);
		endcase
	endfunction

	// offer one item and hold it until the transfer
	task automatic send_item(input logic cmd, input logic [CHAN_W-1:0] ch,
			input logic [TAP_W-1:0] tap, input logic st, input logic [VAL_W-1:0] val,
			input bit may_idle);
		if (may_idle && $urandom_range(0, 99) < 14) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {{(IN_TDATA_W - VAL_W - TAP_W - CHAN_W - 1){1'b0}}, val, st, tap, ch};
		do @(posedge clk); while (!s_tready);
		if (cmd == CMD_LOAD && taps_loaded[ch] != '1) begin
			taps_loaded[ch][tap] = 1'b1;
			if (taps_loaded[ch] == '1)
				ready_q.push_back(ch);
		end
	endtask

	// stop offering until every predicted result has come out
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	initial begin
		int               n;
		int               r;
		bit               idle_ok;
		logic [CHAN_W-1:0] ch;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tuser  = CMD_SAMPLE;
		s_tdata  = '0;
		for (int c = 0; c < CHANNELS; c++)
			taps_loaded[c] = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: most negative weights and samples give the largest sum
		for (int t = 0; t < TAPS; t++)
			send_item(CMD_LOAD, 6'd63, TAP_W'(t), 1'b0, 16'h8000, 1'b1);
		send_item(CMD_SAMPLE, 6'd63, '0, 1'b1, 16'h8000, 1'b1);
		send_item(CMD_SAMPLE, 6'd63, '0, 1'b0, 16'h8000, 1'b1);
		send_item(CMD_SAMPLE, 6'd63, '0, 1'b0, 16'h8000, 1'b1);
		send_item(CMD_SAMPLE, 6'd63, '0, 1'b0, 16'h8000, 1'b1);
		send_item(CMD_SAMPLE, 6'd63, '0, 1'b0, 16'h7FFF, 1'b1);
		// mixed-sign weights, a sequence restart mid-stream and a weight reload
		send_item(CMD_LOAD, 6'd0, 2'd0, 1'b0, 16'h7FFF, 1'b1);
		send_item(CMD_LOAD, 6'd0, 2'd1, 1'b0, 16'h8000, 1'b1);
		send_item(CMD_LOAD, 6'd0, 2'd2, 1'b0, 16'h0001, 1'b1);
		send_item(CMD_LOAD, 6'd0, 2'd3, 1'b0, 16'hFFFF, 1'b1);
		send_item(CMD_SAMPLE, 6'd0, '0, 1'b0, 16'h7FFF, 1'b1);
		send_item(CMD_SAMPLE, 6'd0, '0, 1'b0, 16'h8000, 1'b1);
		send_item(CMD_SAMPLE, 6'd0, '0, 1'b0, 16'h0000, 1'b1);
		send_item(CMD_SAMPLE, 6'd0, '0, 1'b1, 16'h0001, 1'b1);
		send_item(CMD_SAMPLE, 6'd0, '0, 1'b0, 16'hFFFF, 1'b1);
		send_item(CMD_LOAD, 6'd0, 2'd3, 1'b0, 16'h7FFF, 1'b1);
		send_item(CMD_SAMPLE, 6'd0, '0, 1'b0, 16'h7FFF, 1'b1);
		drain();

		// random: interleaved sequences on loaded channels, with full-row and single-tap loads
		n = 0;
		while (n < RAND_ITEMS) begin
			if (n >= 500 && n < 504)
				drain();
			idle_ok = !(n >= 300 && n < 450);
			r = $urandom_range(0, 99);
			if (ready_q.size() == 0 || r < 12) begin
				ch = CHAN_W'($urandom_range(0, CHANNELS - 1));
				if ($urandom_range(0, 1)) begin
					for (int t = 0; t < TAPS; t++)
						send_item(CMD_LOAD, ch, TAP_W'(t), 1'($urandom), pick_value(),
							idle_ok);
					n += TAPS;
				end else begin
					send_item(CMD_LOAD, ch, TAP_W'($urandom), 1'($urandom), pick_value(),
						idle_ok);
					n++;
				end
			end else begin
				ch = CHAN_W'(ready_q[$urandom_range(0, ready_q.size() - 1)]);
				send_item(CMD_SAMPLE, ch, TAP_W'($urandom), (r < 22), pick_value(),
					idle_ok);
				n++;
			end
		end

		// wait for the tail, then let the block run on before the verdict
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (10) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
